/* hw/rtl/fce_pkg.sv */
// Shared constants, action codes and the table write request type for the
// chain engine. No dependencies.
`default_nettype none

package fce_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int LINK_W      = $clog2(TABLE_DEPTH + 2);
    localparam int FIELD_W     = 6;
    localparam int ACT_W       = 3;

    localparam logic [LINK_W-1:0] CODE_FREE = LINK_W'(TABLE_DEPTH);
    localparam logic [LINK_W-1:0] CODE_END  = LINK_W'(TABLE_DEPTH + 1);

    localparam logic [ACT_W-1:0] ACT_CLEAR    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ALLOCATE = 3'd1;
    localparam logic [ACT_W-1:0] ACT_APPEND   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_TRUNCATE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_LIST     = 3'd4;

    typedef struct packed {
        logic              clr;
        logic              we;
        logic [IDX_W-1:0]  addr;
        logic [LINK_W-1:0] data;
    } fce_wr_t;

endpackage

`default_nettype wire

/* hw/rtl/fat_chain_engine.sv */
// Top level of the chain engine: action decode, walk sequencer and output
// register. Uses fce_pkg and fce_table.
`default_nettype none

// Clear, allocate and truncate leave the engine idle and give no result.
// Append and list walk the chain one table entry per cycle, while the output is
// free, through the table's single registered read port: the first read is
// issued as the item is taken, then one per block visited, for a chain of at
// most TABLE_DEPTH blocks. An append that links a block then makes its two
// table writes in turn on the one write port. Each listed block is one result
// item; a stalled output holds the walk. in_stall is high for the whole walk.
module fat_chain_engine (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [fce_pkg::ACT_W-1:0]     action,
    input  wire logic [fce_pkg::FIELD_W-1:0]   target_block,
    input  wire logic [fce_pkg::FIELD_W-1:0]   new_block,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [fce_pkg::FIELD_W-1:0]   block_index,
    output logic                               last_of_run,
    output logic                               status
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_WR2  = 2'd2;

    logic [1:0]                    state_reg, state_next;
    logic                          list_reg, list_next;
    logic [fce_pkg::IDX_W-1:0]     blk_reg, blk_next;
    logic [fce_pkg::IDX_W-1:0]     cnt_reg, cnt_next;
    logic [fce_pkg::IDX_W-1:0]     fresh_reg, fresh_next;
    logic                          fresh_ok_reg, fresh_ok_next;

    logic                          out_valid_reg;
    logic [fce_pkg::IDX_W-1:0]     out_blk_reg;
    logic                          out_last_reg;
    logic                          out_status_reg;

    fce_pkg::fce_wr_t              wr;
    logic                          re;
    logic [fce_pkg::IDX_W-1:0]     raddr;
    logic [fce_pkg::LINK_W-1:0]    rdata;

    logic                          in_acc;
    logic                          target_ok;
    logic                          out_free;
    logic                          more;
    logic                          loop_hit;
    logic                          walk_end;
    logic                          emit;
    logic                          emit_last;

    fce_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign target_ok = ({1'b0, target_block} < (fce_pkg::FIELD_W + 1)'(fce_pkg::TABLE_DEPTH));
    assign out_free  = !out_valid_reg || !out_stall;

    assign more     = (rdata < fce_pkg::LINK_W'(fce_pkg::TABLE_DEPTH));
    assign loop_hit = more && (cnt_reg == fce_pkg::IDX_W'(fce_pkg::TABLE_DEPTH - 1));
    assign walk_end = !more || loop_hit;

    always_comb
    begin
        state_next    = state_reg;
        list_next     = list_reg;
        blk_next      = blk_reg;
        cnt_next      = cnt_reg;
        fresh_next    = fresh_reg;
        fresh_ok_next = fresh_ok_reg;
        wr            = '0;
        re            = 1'b0;
        raddr         = blk_reg;
        emit          = 1'b0;
        emit_last     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (action)
                        fce_pkg::ACT_CLEAR:
                        begin
                            wr.clr = 1'b1;
                        end
                        fce_pkg::ACT_ALLOCATE,
                        fce_pkg::ACT_TRUNCATE:
                        begin
                            wr.we   = target_ok;
                            wr.addr = target_block[fce_pkg::IDX_W-1:0];
                            wr.data = fce_pkg::CODE_END;
                        end
                        fce_pkg::ACT_APPEND,
                        fce_pkg::ACT_LIST:
                        begin
                            if (target_ok)
                            begin
                                re            = 1'b1;
                                raddr         = target_block[fce_pkg::IDX_W-1:0];
                                blk_next      = target_block[fce_pkg::IDX_W-1:0];
                                cnt_next      = '0;
                                list_next     = (action == fce_pkg::ACT_LIST);
                                fresh_next    = new_block[fce_pkg::IDX_W-1:0];
                                fresh_ok_next = ({1'b0, new_block} <
                                                 (fce_pkg::FIELD_W + 1)'(fce_pkg::TABLE_DEPTH));
                                state_next    = S_EVAL;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_EVAL:
            begin
                if (list_reg)
                begin
                    if (out_free)
                    begin
                        emit      = 1'b1;
                        emit_last = walk_end;
                        if (walk_end)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            re       = 1'b1;
                            raddr    = rdata[fce_pkg::IDX_W-1:0];
                            blk_next = rdata[fce_pkg::IDX_W-1:0];
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                end
                else if (!walk_end)
                begin
                    re       = 1'b1;
                    raddr    = rdata[fce_pkg::IDX_W-1:0];
                    blk_next = rdata[fce_pkg::IDX_W-1:0];
                    cnt_next = cnt_reg + 1'b1;
                end
                else if (out_free)
                begin
                    // append: report the old chain end, then link the new block
                    emit      = 1'b1;
                    emit_last = 1'b1;
                    if (!loop_hit && fresh_ok_reg)
                    begin
                        wr.we      = 1'b1;
                        wr.addr    = blk_reg;
                        wr.data    = fce_pkg::LINK_W'(fresh_reg);
                        state_next = S_WR2;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_WR2:
            begin
                wr.we      = 1'b1;
                wr.addr    = fresh_reg;
                wr.data    = fce_pkg::CODE_END;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        list_reg     <= list_next;
        blk_reg      <= blk_next;
        cnt_reg      <= cnt_next;
        fresh_reg    <= fresh_next;
        fresh_ok_reg <= fresh_ok_next;
        if (emit)
        begin
            out_blk_reg    <= blk_reg;
            out_last_reg   <= emit_last;
            out_status_reg <= loop_hit;
        end
    end

    assign out_valid   = out_valid_reg;
    assign block_index = fce_pkg::FIELD_W'(out_blk_reg);
    assign last_of_run = out_last_reg;
    assign status      = out_status_reg;

endmodule

`default_nettype wire

/* hw/rtl/fce_table.sv */
// Link table: one-port write, registered single read, per-entry valid flops
// so that reset and clear make every entry read as free at once. Uses fce_pkg.
`default_nettype none

module fce_table (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire fce_pkg::fce_wr_t             wr,
    input  wire logic                         re,
    input  wire logic [fce_pkg::IDX_W-1:0]    raddr,
    output logic      [fce_pkg::LINK_W-1:0]   rdata
);

    logic [fce_pkg::LINK_W-1:0]      mem [fce_pkg::TABLE_DEPTH];
    logic [fce_pkg::TABLE_DEPTH-1:0] valid_reg;
    logic [fce_pkg::LINK_W-1:0]      rdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.clr)
        begin
            valid_reg <= '0;
        end
        else if (wr.we)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= valid_reg[raddr] ? mem[raddr] : fce_pkg::CODE_FREE;
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hw/rtl/fce_checker.sv */
// Port-level checks for the chain engine, bound to fat_chain_engine.
// Uses fce_pkg for the action codes.
`default_nettype none

module fce_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_stall,
    input  wire logic [fce_pkg::ACT_W-1:0]     action,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire logic [fce_pkg::FIELD_W-1:0]   block_index,
    input  wire logic                          last_of_run,
    input  wire logic                          status
);

    // a held result item keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(block_index)
            && $stable(last_of_run) && $stable(status))
        else $error("stalled output item changed");

    // table-only actions finish in the accepting cycle
    a_quick_action: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && action != fce_pkg::ACT_APPEND
            && action != fce_pkg::ACT_LIST |=> !in_stall)
        else $error("engine busy after a single-cycle action");

    // a walk keeps the input side stalled
    a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (action == fce_pkg::ACT_APPEND
            || action == fce_pkg::ACT_LIST) |=> in_stall)
        else $error("walk did not hold the input");

    // a list item that is not the last means the walk is still running
    a_mid_list: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> in_stall)
        else $error("engine idle with a list still open");

    // loop status only on the final item of a run
    a_loop_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> last_of_run)
        else $error("loop status on a non-final item");

endmodule

bind fat_chain_engine fce_checker u_fce_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .block_index (block_index),
    .last_of_run (last_of_run),
    .status      (status)
);

`default_nettype wire

/* dv/fat_chain_engine_tb.sv */
// Self-checking testbench for fat_chain_engine: directed rows, then a full-length
// chain and random actions, checked against row results or a shadow link table.
// Depends on fce_pkg and the chain engine RTL.
`default_nettype none

module fat_chain_engine_tb;

    localparam logic [fce_pkg::ACT_W-1:0] ACT_RSVD_LO  = 3'd5;
    localparam logic [fce_pkg::ACT_W-1:0] ACT_RSVD_MID = 3'd6;
    localparam logic [fce_pkg::ACT_W-1:0] ACT_RSVD_HI  = 3'd7;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 80;
    localparam int RANDOM_OPS  = 22;

    typedef struct packed {
        logic [fce_pkg::FIELD_W-1:0] blk;
        logic                        last;
        logic                        st;
    } chain_res_t;

    typedef struct packed {
        logic [fce_pkg::ACT_W-1:0]   act;
        logic [fce_pkg::FIELD_W-1:0] tgt;
        logic [fce_pkg::FIELD_W-1:0] nb;
        logic                        typed;
        logic                        has_res;
        logic [fce_pkg::FIELD_W-1:0] res_blk;
    } dir_row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic [fce_pkg::ACT_W-1:0]   action;
    logic [fce_pkg::FIELD_W-1:0] target_block;
    logic [fce_pkg::FIELD_W-1:0] new_block;
    logic                        out_valid;
    logic                        out_stall;
    logic [fce_pkg::FIELD_W-1:0] block_index;
    logic                        last_of_run;
    logic                        status;

    logic [fce_pkg::LINK_W-1:0]  link_shadow [fce_pkg::TABLE_DEPTH];
    chain_res_t                  walk_out [$];
    chain_res_t                  due_results [$];
    dir_row_t                    dir_rows [$];
    int                          err_count;
    int                          idle_cycles;
    int                          burst_left;
    bit                          long_hold_req;
    bit                          hold_done;

    fat_chain_engine i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .target_block (target_block),
        .new_block    (new_block),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .block_index  (block_index),
        .last_of_run  (last_of_run),
        .status       (status)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    task automatic report_error(input string msg);
        $display("ERROR: %s", msg);
        err_count++;
    endtask

    // Shadow of the link table; leaves the results of one action in walk_out.
    task automatic apply_action(input logic [fce_pkg::ACT_W-1:0] act,
                                input logic [fce_pkg::FIELD_W-1:0] tgt,
                                input logic [fce_pkg::FIELD_W-1:0] nb);
        logic [fce_pkg::FIELD_W-1:0] cur;
        logic [fce_pkg::LINK_W-1:0]  nxt;
        int                          visited;
        bit                          more;
        bit                          loop_hit;
        bit                          done;
        chain_res_t                  r;
        walk_out.delete();
        case (act)
            fce_pkg::ACT_CLEAR:
            begin
                for (int i = 0; i < fce_pkg::TABLE_DEPTH; i++)
                    link_shadow[i] = fce_pkg::CODE_FREE;
            end
            fce_pkg::ACT_ALLOCATE, fce_pkg::ACT_TRUNCATE:
            begin
                if (int'(tgt) < fce_pkg::TABLE_DEPTH)
                    link_shadow[tgt] = fce_pkg::CODE_END;
            end
            fce_pkg::ACT_APPEND, fce_pkg::ACT_LIST:
            begin
                if (int'(tgt) < fce_pkg::TABLE_DEPTH)
                begin
                    cur      = tgt;
                    visited  = 0;
                    loop_hit = 1'b0;
                    done     = 1'b0;
                    while (!done)
                    begin
                        nxt  = link_shadow[cur];
                        more = (int'(nxt) < fce_pkg::TABLE_DEPTH);
                        visited++;
                        if (more && visited >= fce_pkg::TABLE_DEPTH)
                            loop_hit = 1'b1;
                        if (act == fce_pkg::ACT_LIST)
                        begin
                            r.blk    = cur;
                            r.last   = !more || loop_hit;
                            r.st     = loop_hit;
                            walk_out = {walk_out, r};
                        end
                        if (!more || loop_hit)
                            done = 1'b1;
                        else
                            cur = nxt[fce_pkg::FIELD_W-1:0];
                    end
                    if (act == fce_pkg::ACT_APPEND)
                    begin
                        r.blk    = cur;
                        r.last   = 1'b1;
                        r.st     = loop_hit;
                        walk_out = {walk_out, r};
                        // link first, end mark second: a self-append ends as end-of-chain
                        if (!loop_hit && int'(nb) < fce_pkg::TABLE_DEPTH)
                        begin
                            link_shadow[cur] = fce_pkg::LINK_W'(nb);
                            link_shadow[nb]  = fce_pkg::CODE_END;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic dir_row_t mk_row(input logic [fce_pkg::ACT_W-1:0] act,
                                        input logic [fce_pkg::FIELD_W-1:0] tgt,
                                        input logic [fce_pkg::FIELD_W-1:0] nb,
                                        input logic typed,
                                        input logic has_res,
                                        input logic [fce_pkg::FIELD_W-1:0] res_blk);
        dir_row_t row;
        row.act     = act;
        row.tgt     = tgt;
        row.nb      = nb;
        row.typed   = typed;
        row.has_res = has_res;
        row.res_blk = res_blk;
        return row;
    endfunction

    function automatic logic [fce_pkg::FIELD_W-1:0] pick_block();
        if ($urandom_range(0, 3) != 0)
            return fce_pkg::FIELD_W'($urandom_range(0, 11));
        return fce_pkg::FIELD_W'($urandom_range(0, fce_pkg::TABLE_DEPTH - 1));
    endfunction

    // Bursts of items with random gaps in between, now and then a long burst.
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 24 : $urandom_range(1, 6);
        end
        burst_left--;
    endtask

    // Offers one item, waits for it to be taken, then records what it should produce.
    task automatic send_item(input dir_row_t row);
        chain_res_t r;
        pace_sender();
        action       <= row.act;
        target_block <= row.tgt;
        new_block    <= row.nb;
        in_valid     <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        apply_action(row.act, row.tgt, row.nb);
        if (row.typed)
        begin
            if (row.has_res)
            begin
                r.blk       = row.res_blk;
                r.last      = 1'b1;
                r.st        = 1'b0;
                due_results = {due_results, r};
            end
        end
        else
        begin
            due_results = {due_results, walk_out};
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        burst_left = 0;
    endtask

    // Result side: stall patterns by segment, plus one long hold on request.
    initial
    begin
        int seg_len;
        int mode;
        hold_done = 1'b0;
        out_stall <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (long_hold_req && !hold_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                seg_len = $urandom_range(16, 64);
                mode    = $urandom_range(0, 2);
                for (int i = 0; i < seg_len; i++)
                begin
                    case (mode)
                        0:       out_stall <= 1'b0;
                        1:       out_stall <= ($urandom_range(0, 3) == 0);
                        default: out_stall <= ($urandom_range(0, 9) < 6);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        chain_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_results.size() == 0)
                report_error($sformatf("unexpected result block %0d last %0b status %0b",
                                       block_index, last_of_run, status));
            else
            begin
                want = due_results.pop_front();
                if (block_index !== want.blk)
                    report_error($sformatf("block_index %0d, want %0d",
                                           block_index, want.blk));
                if (last_of_run !== want.last)
                    report_error($sformatf("last_of_run %0b, want %0b on block %0d",
                                           last_of_run, want.last, want.blk));
                if (status !== want.st)
                    report_error($sformatf("status %0b, want %0b on block %0d",
                                           status, want.st, want.blk));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        logic [fce_pkg::FIELD_W-1:0] perm [fce_pkg::TABLE_DEPTH];
        logic [fce_pkg::FIELD_W-1:0] tmp;
        logic [fce_pkg::ACT_W-1:0]   act;
        int                          j;
        int                          pick;
        err_count     = 0;
        burst_left    = 0;
        long_hold_req = 1'b0;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        action       <= fce_pkg::ACT_CLEAR;
        target_block <= '0;
        new_block    <= '0;
        apply_action(fce_pkg::ACT_CLEAR, '0, '0);

        // after reset every entry is free, and a free block lists as a one-block chain
        dir_rows = {dir_rows, mk_row(fce_pkg::ACT_LIST,     6'd0,  6'd0,  1'b1, 1'b1, 6'd0)};
        dir_rows = {dir_rows, mk_row(fce_pkg::ACT_LIST,     6'd63, 6'd0,  1'b1, 1'b1, 6'd63)};
        dir_rows = {dir_rows, mk_row(ACT_RSVD_LO,           6'd63, 6'd63, 1'b1, 1'b0, 6'd0)};
        dir_rows = {dir_rows, mk_row(ACT_RSVD_MID,          6'd21, 6'd42, 1'b1, 1'b0, 6'd0)};
        dir_rows = {dir_rows, mk_row(ACT_RSVD_HI,           6'd0,  6'd0,  1'b1, 1'b0, 6'd0)};
        dir_rows = {dir_rows, mk_row(fce_pkg::ACT_ALLOCATE, 6'd0,  6'd0,  1'b1, 1'b0, 6'd0)};
        dir_rows = {dir_rows, mk_row(fce_pkg::ACT_APPEND,   6'd0,  6'd63, 1'b1, 1'b1, 6'd0)};
        dir_rows = {dir_rows, mk_row(fce_pkg::ACT_APPEND,   6'd0,  6'd21, 1'b1, 1'b1, 6'd63)};
        dir_rows = {dir_rows, mk_row(fce_pkg::ACT_LIST,     6'd0,  6'd0,  1'b0, 1'b0, 6'd0)};
        // append starting mid-chain
        dir_rows = {dir_rows, mk_row(fce_pkg::ACT_APPEND,   6'd63, 6'd42, 1'b0, 1'b0, 6'd0)};
        dir_rows = {dir_rows, mk_row(fce_pkg::ACT_TRUNCATE, 6'd63, 6'd0,  1'b1, 1'b0, 6'd0)};
        dir_rows = {dir_rows, mk_row(fce_pkg::ACT_LIST,     6'd0,  6'd0,  1'b0, 1'b0, 6'd0)};
        dir_rows = {dir_rows, mk_row(fce_pkg::ACT_LIST,     6'd21, 6'd0,  1'b0, 1'b0, 6'd0)};
        // append of the chain's own last block, then of its first block
        dir_rows = {dir_rows, mk_row(fce_pkg::ACT_APPEND,   6'd21, 6'd42, 1'b0, 1'b0, 6'd0)};
        dir_rows = {dir_rows, mk_row(fce_pkg::ACT_LIST,     6'd21, 6'd0,  1'b0, 1'b0, 6'd0)};
        dir_rows = {dir_rows, mk_row(fce_pkg::ACT_APPEND,   6'd0,  6'd0,  1'b0, 1'b0, 6'd0)};
        dir_rows = {dir_rows, mk_row(fce_pkg::ACT_LIST,     6'd63, 6'd0,  1'b0, 1'b0, 6'd0)};
        dir_rows = {dir_rows, mk_row(fce_pkg::ACT_CLEAR,    6'd63, 6'd63, 1'b1, 1'b0, 6'd0)};
        dir_rows = {dir_rows, mk_row(fce_pkg::ACT_LIST,     6'd21, 6'd0,  1'b1, 1'b1, 6'd21)};
        dir_rows = {dir_rows, mk_row(fce_pkg::ACT_ALLOCATE, 6'd63, 6'd0,  1'b1, 1'b0, 6'd0)};
        dir_rows = {dir_rows, mk_row(fce_pkg::ACT_LIST,     6'd63, 6'd0,  1'b1, 1'b1, 6'd63)};
        dir_rows = {dir_rows, mk_row(fce_pkg::ACT_LIST,     6'd0,  6'd0,  1'b1, 1'b1, 6'd0)};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i]);

        drain_results();

        // a chain through every block, built in random order, then listed in full
        for (int i = 0; i < fce_pkg::TABLE_DEPTH; i++)
            perm[i] = fce_pkg::FIELD_W'(i);
        for (int i = fce_pkg::TABLE_DEPTH - 1; i > 0; i--)
        begin
            j       = $urandom_range(0, i);
            tmp     = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        send_item(mk_row(fce_pkg::ACT_CLEAR, pick_block(), pick_block(), 1'b0, 1'b0, 6'd0));
        send_item(mk_row(fce_pkg::ACT_ALLOCATE, perm[0], pick_block(), 1'b0, 1'b0, 6'd0));
        for (int i = 1; i < fce_pkg::TABLE_DEPTH; i++)
            send_item(mk_row(fce_pkg::ACT_APPEND, perm[$urandom_range(0, i - 1)], perm[i],
                             1'b0, 1'b0, 6'd0));
        // long output hold from here on, while items keep being offered
        long_hold_req = 1'b1;
        send_item(mk_row(fce_pkg::ACT_LIST, perm[0], pick_block(), 1'b0, 1'b0, 6'd0));

        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                act = fce_pkg::ACT_W'($urandom_range(ACT_RSVD_LO, ACT_RSVD_HI));
            else if (pick < 11)
                act = fce_pkg::ACT_CLEAR;
            else if (pick < 26)
                act = fce_pkg::ACT_ALLOCATE;
            else if (pick < 36)
                act = fce_pkg::ACT_TRUNCATE;
            else if (pick < 66)
                act = fce_pkg::ACT_APPEND;
            else
                act = fce_pkg::ACT_LIST;
            send_item(mk_row(act, pick_block(), pick_block(), 1'b0, 1'b0, 6'd0));
        end

        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (due_results.size() != 0)
            report_error($sformatf("%0d results never arrived", due_results.size()));
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
hw/rtl/fce_pkg.sv
hw/rtl/fce_table.sv
hw/rtl/fat_chain_engine.sv
hw/rtl/fce_checker.sv
dv/fat_chain_engine_tb.sv
